// ===== rtl/mfd_pkg.sv =====
// Shared types and constants for the motor feedback decoder.
// No dependencies; every other file in rtl/ refers to this package by scoped names.

package mfd_pkg;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_SMOOTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_SMOOTH   = 1'b1;

    // Filter weights are unsigned 16-bit numbers.
    localparam int                COEF_W       = 16;
    localparam logic [COEF_W-1:0] SMOOTH_RESET = 16'h8000;

    // Filter state widths.
    localparam int CURRENT_W = 16;
    localparam int SPEED_W   = 24;
    localparam int SAMPLE_W  = 16;

    // Encoder and turn counter.
    localparam int ENC_W  = 16;
    localparam int TURN_W = 32;
    localparam int POS_W  = TURN_W + ENC_W;

    // Half a revolution in encoder counts, as a signed jump limit.
    localparam logic signed [ENC_W:0] ENC_HALF_POS = 17'sd32768;
    localparam logic signed [ENC_W:0] ENC_HALF_NEG = -17'sd32768;

    // One feedback frame as it sits in the input register.
    typedef struct packed {
        logic [7:0]          temperature;
        logic [SAMPLE_W-1:0] current;
        logic [SAMPLE_W-1:0] speed;
        logic [ENC_W-1:0]    encoder;
    } frame_t;

endpackage

// ===== rtl/mfd_lowpass.sv =====
// First-order low-pass filter with its state register, updated once per enable.
// Depends on mfd_pkg for the coefficient width.

module mfd_lowpass #(
    parameter int STATE_W   = 16,
    parameter int RAW_W     = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            update_en,
    input  logic [mfd_pkg::COEF_W-1:0]      coef,
    input  logic signed [RAW_W-1:0]         raw,
    output logic signed [STATE_W-1:0]       value
);

    localparam int DIFF_W = ((STATE_W > RAW_W) ? STATE_W : RAW_W) + 1;
    localparam int PROD_W = DIFF_W + mfd_pkg::COEF_W + 1;
    localparam int NUM_W  = ((STATE_W + FRAC_BITS > PROD_W) ?
                             (STATE_W + FRAC_BITS) : PROD_W) + 1;

    localparam logic signed [NUM_W-1:0] ROUND_BIAS = (NUM_W'(1) << FRAC_BITS) - NUM_W'(1);
    localparam logic signed [NUM_W-1:0] NO_BIAS    = NUM_W'(0);
    localparam logic signed [NUM_W-1:0] SAT_HI =
        {{(NUM_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
    localparam logic signed [NUM_W-1:0] SAT_LO =
        {{(NUM_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};

    logic signed [STATE_W-1:0]          state_reg;
    logic signed [STATE_W-1:0]          state_next;
    logic signed [DIFF_W-1:0]           diff;
    logic signed [mfd_pkg::COEF_W:0]    coef_s;
    logic signed [PROD_W-1:0]           prod;
    logic signed [NUM_W-1:0]            num;
    logic signed [NUM_W-1:0]            quot;

    assign diff   = DIFF_W'(raw) - DIFF_W'(state_reg);
    assign coef_s = $signed({1'b0, coef});
    assign prod   = PROD_W'(diff) * PROD_W'(coef_s);
    assign num    = (NUM_W'(state_reg) <<< FRAC_BITS) + NUM_W'(prod);

    // Adding the bias before the arithmetic shift makes negative values truncate toward zero.
    assign quot = (num + (num[NUM_W-1] ? ROUND_BIAS : NO_BIAS)) >>> FRAC_BITS;

    always_comb begin
        if (quot > SAT_HI) begin
            state_next = SAT_HI[STATE_W-1:0];
        end else if (quot < SAT_LO) begin
            state_next = SAT_LO[STATE_W-1:0];
        end else begin
            state_next = quot[STATE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (update_en) begin
            state_reg <= state_next;
        end
    end

    assign value = state_reg;

endmodule

// ===== rtl/mfd_turns.sv =====
// Multi-turn tracker: last encoder reading and a wrapping signed turn counter.
// Depends on mfd_pkg for widths and the half-turn jump limits.

module mfd_turns (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                update_en,
    input  logic [mfd_pkg::ENC_W-1:0]           encoder,
    output logic [mfd_pkg::ENC_W-1:0]           last_encoder,
    output logic signed [mfd_pkg::TURN_W-1:0]   turns
);

    localparam logic [mfd_pkg::TURN_W-1:0] TURN_STEP = {{(mfd_pkg::TURN_W-1){1'b0}}, 1'b1};

    logic [mfd_pkg::ENC_W-1:0]          last_encoder_reg;
    logic [mfd_pkg::TURN_W-1:0]         turns_reg;
    logic [mfd_pkg::TURN_W-1:0]         turns_next;
    logic signed [mfd_pkg::ENC_W:0]     delta;

    assign delta = $signed({1'b0, encoder}) - $signed({1'b0, last_encoder_reg});

    // A jump of more than half a turn means the encoder wrapped; exactly half does nothing.
    always_comb begin
        if (delta > mfd_pkg::ENC_HALF_POS) begin
            turns_next = turns_reg - TURN_STEP;
        end else if (delta < mfd_pkg::ENC_HALF_NEG) begin
            turns_next = turns_reg + TURN_STEP;
        end else begin
            turns_next = turns_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_encoder_reg <= '0;
            turns_reg        <= '0;
        end else if (update_en) begin
            last_encoder_reg <= encoder;
            turns_reg        <= turns_next;
        end
    end

    assign last_encoder = last_encoder_reg;
    assign turns        = $signed(turns_reg);

endmodule

// ===== rtl/motor_feedback_decoder_unit.sv =====
// Top level of the motor feedback decoder: input register, filters, turn tracker, result register.
// Depends on mfd_pkg, mfd_lowpass and mfd_turns.

// The block decodes motor feedback words at a sustained rate of one word every clock while the
// result side takes them; a held result stalls the input. A word waits in the input register,
// then moves into the filter and turn states, which double as the result register, and is
// offered from there. The rate is set by the filter update: a signed multiply of the weight by
// the difference between sample and state, one add and a saturation, all combinational and fed
// back into the filter state on each update, so the next word always sees the state left by
// the one before it. Current and speed are smoothed with new = old + weight*(sample - old), the
// weight being unsigned with COEF_FRAC_BITS fraction bits; the current result truncates toward
// zero to 16 bits and the speed is kept with SPEED_FRAC_BITS fraction bits in 24 bits, both
// saturating. The turn counter moves down by one on an encoder jump above half a turn and up by
// one on a jump below minus half a turn, and wraps. The absolute position is the turn count
// times 65536 plus the encoder reading. The user must write weights through the configuration
// port only while no word is in flight; the block does not enforce this. Both reset to one half.

module motor_feedback_decoder_unit #(
    parameter int COEF_FRAC_BITS  = 16,
    parameter int SPEED_FRAC_BITS = 8
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    input  logic                                    cfg_wr_en,
    input  logic [mfd_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [mfd_pkg::CFG_DATA_W-1:0]          cfg_wdata,

    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [7:0]                              s_temperature_byte,
    input  logic [7:0]                              s_current_low,
    input  logic [7:0]                              s_current_high,
    input  logic [7:0]                              s_speed_low,
    input  logic [7:0]                              s_speed_high,
    input  logic [7:0]                              s_encoder_low,
    input  logic [7:0]                              s_encoder_high,

    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [7:0]                              m_temperature,
    output logic signed [mfd_pkg::CURRENT_W-1:0]    m_filtered_current,
    output logic signed [mfd_pkg::SPEED_W-1:0]      m_filtered_speed,
    output logic [mfd_pkg::ENC_W-1:0]               m_encoder_count,
    output logic signed [mfd_pkg::TURN_W-1:0]       m_turn_count,
    output logic signed [mfd_pkg::POS_W-1:0]        m_absolute_position
);

    localparam int SPEED_RAW_W = mfd_pkg::SAMPLE_W + SPEED_FRAC_BITS;

    logic [mfd_pkg::COEF_W-1:0]     current_smooth_reg;
    logic [mfd_pkg::COEF_W-1:0]     speed_smooth_reg;

    mfd_pkg::frame_t                frame_reg;
    logic                           in_valid_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [7:0]                     temperature_reg;
    logic                           advance;
    logic                           s_accept;

    logic signed [SPEED_RAW_W-1:0]  speed_raw;

    // Configuration registers. Writes must come only while the datapath is empty; not enforced.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_smooth_reg <= mfd_pkg::SMOOTH_RESET;
            speed_smooth_reg   <= mfd_pkg::SMOOTH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mfd_pkg::REG_CURRENT_SMOOTH: begin
                    current_smooth_reg <= cfg_wdata[mfd_pkg::COEF_W-1:0];
                end
                mfd_pkg::REG_SPEED_SMOOTH: begin
                    speed_smooth_reg <= cfg_wdata[mfd_pkg::COEF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // A word moves from the input register into the result stage whenever the result
    // register is empty or is being emptied in this cycle. The input register in turn
    // takes a new word whenever it is empty or moving on, so both sides keep streaming.
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            frame_reg.temperature <= s_temperature_byte;
            frame_reg.current     <= {s_current_high, s_current_low};
            frame_reg.speed       <= {s_speed_high, s_speed_low};
            frame_reg.encoder     <= {s_encoder_high, s_encoder_low};
        end
    end

    always_comb begin
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            temperature_reg <= frame_reg.temperature;
        end
    end

    // The filter and turn states are updated exactly when a word enters the result stage,
    // and they hold until the next one does, so they double as the result register.
    assign speed_raw = SPEED_RAW_W'($signed(frame_reg.speed)) <<< SPEED_FRAC_BITS;

    mfd_lowpass #(
        .STATE_W   (mfd_pkg::CURRENT_W),
        .RAW_W     (mfd_pkg::SAMPLE_W),
        .FRAC_BITS (COEF_FRAC_BITS)
    ) u_current_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .update_en (advance),
        .coef      (current_smooth_reg),
        .raw       ($signed(frame_reg.current)),
        .value     (m_filtered_current)
    );

    mfd_lowpass #(
        .STATE_W   (mfd_pkg::SPEED_W),
        .RAW_W     (SPEED_RAW_W),
        .FRAC_BITS (COEF_FRAC_BITS)
    ) u_speed_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .update_en (advance),
        .coef      (speed_smooth_reg),
        .raw       (speed_raw),
        .value     (m_filtered_speed)
    );

    mfd_turns u_turns (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .update_en    (advance),
        .encoder      (frame_reg.encoder),
        .last_encoder (m_encoder_count),
        .turns        (m_turn_count)
    );

    assign m_valid       = out_valid_reg;
    assign m_temperature = temperature_reg;

    // The encoder reading is below 65536, so the product and sum reduce to a concatenation.
    assign m_absolute_position = $signed({m_turn_count, m_encoder_count});

    // A word that enters the result stage is offered on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("word entered result stage but no result is offered");

    // The input side only stalls when both registers are full and the result is held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled while the datapath could move");

    // The turn count moves by at most one per word and only when a word advances.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_turn_count == $past(m_turn_count))
                 || (m_turn_count == $past(m_turn_count) + 32'sd1)
                 || (m_turn_count == $past(m_turn_count) - 32'sd1))
        else $error("turn count jumped by more than one");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(m_turn_count) && $stable(m_filtered_current)
                      && $stable(m_filtered_speed)))
        else $error("state changed without a word advancing");

endmodule
